@@ sv/cchv_pkg.sv @@
// Constants, header offsets and logo tables for the cartridge header checksum verifier.
// No dependencies; imported by cart_header_checksum_verifier_core.
package cchv_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LOGO_LENGTH   = 48;
    localparam int LOGO_IDX_BITS = $clog2(LOGO_LENGTH);
    localparam int SKIP_BITS     = 10;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [SKIP_BITS-1:0]     skip_t;
    typedef logic [LOGO_IDX_BITS-1:0] logo_idx_t;

    localparam int unsigned HDR_BASE = 32'h100;

    localparam pos_t POS_MAX        = '1;
    localparam pos_t OFS_ENTRY0     = pos_t'(HDR_BASE);
    localparam pos_t OFS_ENTRY1     = pos_t'(HDR_BASE + 32'h01);
    localparam pos_t OFS_LOGO       = pos_t'(HDR_BASE + 32'h04);
    localparam pos_t OFS_HSUM_FIRST = pos_t'(HDR_BASE + 32'h34);
    localparam pos_t OFS_TYPE       = pos_t'(HDR_BASE + 32'h47);
    localparam pos_t OFS_HSUM_BYTE  = pos_t'(HDR_BASE + 32'h4d);
    localparam pos_t OFS_GSUM_HI    = pos_t'(HDR_BASE + 32'h4e);
    localparam pos_t OFS_GSUM_LO    = pos_t'(HDR_BASE + 32'h4f);
    localparam pos_t LOGO_LEN_POS   = pos_t'(LOGO_LENGTH);

    localparam logic [7:0] ENTRY0_BYTE = 8'h00;
    localparam logic [7:0] ENTRY1_BYTE = 8'hc3;
    localparam logic [7:0] ALT_TYPE_LO = 8'h97;
    localparam logic [7:0] ALT_TYPE_HI = 8'h99;

    localparam logic [7:0] STD_LOGO [LOGO_LENGTH] = '{
        8'hce, 8'hed, 8'h66, 8'h66, 8'hcc, 8'h0d, 8'h00, 8'h0b,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0c, 8'h00, 8'h0d,
        8'h00, 8'h08, 8'h11, 8'h1f, 8'h88, 8'h89, 8'h00, 8'h0e,
        8'hdc, 8'hcc, 8'h6e, 8'he6, 8'hdd, 8'hdd, 8'hd9, 8'h99,
        8'hbb, 8'hbb, 8'h67, 8'h63, 8'h6e, 8'h0e, 8'hec, 8'hcc,
        8'hdd, 8'hdc, 8'h99, 8'h9f, 8'hbb, 8'hb9, 8'h33, 8'h3e
    };

    localparam logic [7:0] ALT_LOGO [LOGO_LENGTH] = '{
        8'h11, 8'h23, 8'hf1, 8'h1e, 8'h01, 8'h22, 8'hf0, 8'h00,
        8'h08, 8'h99, 8'h78, 8'h00, 8'h08, 8'h11, 8'h9a, 8'h48,
        8'h11, 8'h23, 8'hf0, 8'h0e, 8'h70, 8'h01, 8'hf8, 8'h80,
        8'h22, 8'h44, 8'h44, 8'h22, 8'h22, 8'h21, 8'h00, 8'h1e,
        8'h99, 8'h10, 8'h00, 8'h1e, 8'h19, 8'h22, 8'h44, 8'h22,
        8'h22, 8'h47, 8'h00, 8'h0e, 8'h11, 8'h22, 8'h00, 8'h00
    };

endpackage

@@ sv/cart_header_checksum_verifier_core.sv @@
// Top level of the cartridge header and global checksum verifier.
// Depends on cchv_pkg for offsets, widths and the logo tables.

// Streams a cartridge image at one byte per clock unless in_stall holds it: each
// item passes an input register, then a single stage updates the running sums and
// match flags and, on the item marked last, loads the result register and sets
// out_valid. Non-last items keep flowing while a result waits to be taken; only
// a last item stalls behind an unread result. The user must write skip_bytes
// (cfg_wr_data) with cfg_wr_en while the block is idle; it does not enforce it.
module cart_header_checksum_verifier_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  cchv_pkg::skip_t       cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            header_sum,
    output logic [15:0]           global_sum,
    output logic [15:0]           stored_global,
    output logic                  header_ok,
    output logic                  global_ok,
    output logic                  entry_ok,
    output logic                  logo_ok,
    output logic                  too_short
);
    import cchv_pkg::*;

    skip_t       skip_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_data_reg;
    logic        s1_last_reg;
    logic        in_accept, s1_block, s1_go;

    pos_t        pos_reg, pos_next;
    logic [7:0]  hacc_reg, hacc_next;
    logic [15:0] gacc_reg, gacc_next;
    logic [7:0]  shdr_reg, shdr_next;
    logic [15:0] sglb_reg, sglb_next;
    logic [7:0]  type_reg, type_next;
    logic [1:0]  entry_reg, entry_next;
    logic [1:0]  logo_reg, logo_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  res_hsum_reg;
    logic [15:0] res_gsum_reg, res_sglb_reg;
    logic        res_hok_reg, res_gok_reg, res_eok_reg, res_lok_reg, res_short_reg;

    pos_t        skip_pos, off, logo_rel;
    logic        in_image, in_logo, is_short, alt_sel, logo_pass;
    logo_idx_t   logo_idx;

    assign s1_block  = s1_valid_reg && s1_last_reg && out_valid_reg && out_stall;
    assign in_stall  = s1_block;
    assign in_accept = in_valid && !in_stall;
    assign s1_go     = s1_valid_reg && !s1_block;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign skip_pos = pos_t'(skip_reg);
    assign in_image = pos_reg >= skip_pos;
    assign off      = in_image ? (pos_reg - skip_pos) : '0;
    assign logo_rel = off - OFS_LOGO;
    assign in_logo  = (off >= OFS_LOGO) && (logo_rel < LOGO_LEN_POS);
    assign logo_idx = logo_rel[LOGO_IDX_BITS-1:0];

    always_comb
    begin
        hacc_next  = hacc_reg;
        gacc_next  = gacc_reg;
        shdr_next  = shdr_reg;
        sglb_next  = sglb_reg;
        type_next  = type_reg;
        entry_next = entry_reg;
        logo_next  = logo_reg;
        pos_next   = (pos_reg != POS_MAX) ? pos_reg + pos_t'(1) : pos_reg;

        if (in_image)
        begin
            if (off == OFS_ENTRY0 && s1_data_reg == ENTRY0_BYTE)
                entry_next[0] = 1'b1;
            if (off == OFS_ENTRY1 && s1_data_reg == ENTRY1_BYTE)
                entry_next[1] = 1'b1;
            if (in_logo)
            begin
                if (s1_data_reg != STD_LOGO[logo_idx])
                    logo_next[0] = 1'b0;
                if (s1_data_reg != ALT_LOGO[logo_idx])
                    logo_next[1] = 1'b0;
            end
            if (off == OFS_TYPE)
                type_next = s1_data_reg;
            if (off >= OFS_HSUM_FIRST && off < OFS_HSUM_BYTE)
                hacc_next = hacc_reg + ~s1_data_reg;

            if (off == OFS_HSUM_BYTE)
            begin
                shdr_next = s1_data_reg;
                gacc_next = gacc_reg + {8'h00, hacc_reg};
            end
            else if (off == OFS_GSUM_HI)
                sglb_next = {s1_data_reg, sglb_reg[7:0]};
            else if (off == OFS_GSUM_LO)
                sglb_next = {sglb_reg[15:8], s1_data_reg};
            else
                gacc_next = gacc_reg + {8'h00, s1_data_reg};
        end
    end

    assign is_short  = !in_image || (off < OFS_GSUM_LO);
    assign alt_sel   = type_next inside {[ALT_TYPE_LO:ALT_TYPE_HI]};
    assign logo_pass = alt_sel ? logo_next[1] : logo_next[0];

    always_comb
    begin
        if (s1_go && s1_last_reg)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            hacc_reg      <= '0;
            gacc_reg      <= '0;
            shdr_reg      <= '0;
            sglb_reg      <= '0;
            type_reg      <= '0;
            entry_reg     <= '0;
            logo_reg      <= 2'b11;
        end
        else
        begin
            if (cfg_wr_en)
                skip_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_go)
            begin
                if (s1_last_reg)
                begin
                    pos_reg   <= '0;
                    hacc_reg  <= '0;
                    gacc_reg  <= '0;
                    shdr_reg  <= '0;
                    sglb_reg  <= '0;
                    type_reg  <= '0;
                    entry_reg <= '0;
                    logo_reg  <= 2'b11;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    hacc_reg  <= hacc_next;
                    gacc_reg  <= gacc_next;
                    shdr_reg  <= shdr_next;
                    sglb_reg  <= sglb_next;
                    type_reg  <= type_next;
                    entry_reg <= entry_next;
                    logo_reg  <= logo_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_go && s1_last_reg)
        begin
            res_hsum_reg  <= hacc_next;
            res_gsum_reg  <= gacc_next;
            res_sglb_reg  <= sglb_next;
            res_hok_reg   <= !is_short && (hacc_next == shdr_next);
            res_gok_reg   <= !is_short && (gacc_next == sglb_next);
            res_eok_reg   <= !is_short && (entry_next == 2'b11);
            res_lok_reg   <= !is_short && logo_pass;
            res_short_reg <= is_short;
        end
    end

    assign out_valid     = out_valid_reg;
    assign header_sum    = res_hsum_reg;
    assign global_sum    = res_gsum_reg;
    assign stored_global = res_sglb_reg;
    assign header_ok     = res_hok_reg;
    assign global_ok     = res_gok_reg;
    assign entry_ok      = res_eok_reg;
    assign logo_ok       = res_lok_reg;
    assign too_short     = res_short_reg;

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && s1_valid_reg))
        else $error("input stalled without a pending result");

    a_short_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_short) |-> (!header_ok && !global_ok && !entry_ok && !logo_ok))
        else $error("pass flag set on a short image");

    a_global_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (global_ok == (!too_short && (global_sum == stored_global))))
        else $error("global_ok disagrees with sums");

    a_state_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> (pos_reg == '0 && logo_reg == 2'b11))
        else $error("stream state not cleared after last item");

endmodule
